@@ rtl/nrpc_pkg.sv @@
// Shared types, constants and the distance function of the palette color matcher.
package nrpc_pkg;

  // One 6-bit color component.
  typedef logic [5:0] comp_t;

  // Palette entry layout: red in the top bits, then green, then blue.
  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } palette_entry_t;

  // Largest real distance is 3 * 63 = 189, which fits in 8 bits.
  typedef logic [7:0] dist_t;

  // Best-distance register, wide enough for the start value.
  typedef logic [12:0] best_dist_t;

  localparam best_dist_t START_DISTANCE = 13'h1000;
  localparam logic [7:0] OPAQUE_ALPHA   = 8'hFF;

  // Item kinds on the request channel.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } search_state_t;

  // Start of a pixel request, handed from the top level to the search engine.
  typedef struct packed {
    logic           start;
    logic           opaque;
    palette_entry_t color;
  } pixel_req_t;

  // Sum of absolute component differences between two colors.
  function automatic dist_t color_distance(palette_entry_t a, palette_entry_t b);
    dist_t dr;
    dist_t dg;
    dist_t db;
    dr = (a.red   > b.red)   ? dist_t'(a.red   - b.red)   : dist_t'(b.red   - a.red);
    dg = (a.green > b.green) ? dist_t'(a.green - b.green) : dist_t'(b.green - a.green);
    db = (a.blue  > b.blue)  ? dist_t'(a.blue  - b.blue)  : dist_t'(b.blue  - a.blue);
    return dr + dg + db;
  endfunction

endpackage

@@ rtl/nrpc_req_if.sv @@
// Request channel: palette loads and pixels to quantize.
interface nrpc_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] entry_index;
  logic [5:0] entry_red;
  logic [5:0] entry_green;
  logic [5:0] entry_blue;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_alpha;

  modport source (
    output valid, func, entry_index, entry_red, entry_green, entry_blue,
           pixel_red, pixel_green, pixel_blue, pixel_alpha,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_red, entry_green, entry_blue,
           pixel_red, pixel_green, pixel_blue, pixel_alpha,
    output ready
  );
endinterface

@@ rtl/nrpc_rsp_if.sv @@
// Result channel: one palette index per pixel request.
interface nrpc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (
    output valid, color_index,
    input  ready
  );

  modport sink (
    input  valid, color_index,
    output ready
  );
endinterface

@@ rtl/nrpc_palette.sv @@
// Palette memory: one write port, one registered read port.
module nrpc_palette
  import nrpc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  palette_entry_t wr_data,
  input  logic [AW-1:0]  rd_addr,
  output palette_entry_t rd_data
);

  palette_entry_t mem [DEPTH];

  // Write a loaded entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: rd_data follows rd_addr in the next cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/nrpc_search.sv @@
// Search engine: walks the palette one entry per cycle and keeps the nearest match.
module nrpc_search
  import nrpc_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pixel_req_t     req,
  output logic           idle,
  output logic [AW-1:0]  rd_addr,
  input  palette_entry_t rd_data,
  nrpc_rsp_if.source     result
);

  localparam logic [AW-1:0] LAST_ADDR  = AW'(ENTRIES - 1);
  localparam logic [AW-1:0] FIRST_ADDR = AW'(1);

  search_state_t  state;
  search_state_t  state_next;
  logic           issue_active;
  logic [AW-1:0]  issue_addr;
  logic           eval_valid;
  logic [AW-1:0]  eval_idx;
  logic [AW-1:0]  best_idx;
  best_dist_t     best_dist;
  palette_entry_t pix;
  logic           res_valid;
  logic [7:0]     res_index;

  dist_t cand_dist;
  logic  hit;
  logic  eval_last;
  logic  better;
  logic  slot_free;
  logic  res_load;

  // Distance of the entry read in the previous cycle.
  assign cand_dist = color_distance(pix, rd_data);
  assign hit       = eval_valid && (cand_dist == '0);
  assign eval_last = eval_valid && (eval_idx == LAST_ADDR);
  assign better    = eval_valid && (best_dist_t'(cand_dist) < best_dist);
  assign slot_free = !res_valid || result.ready;
  assign rd_addr   = issue_addr;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.start) begin
          state_next = req.opaque ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (hit || eval_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    idle     = (state == ST_IDLE);
    res_load = (state == ST_FINISH) && slot_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue_active <= 1'b0;
      eval_valid   <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        issue_active <= req.start && req.opaque;
        eval_valid   <= 1'b0;
      end else if (state == ST_SEARCH) begin
        if (hit || (issue_active && issue_addr == LAST_ADDR)) begin
          issue_active <= 1'b0;
        end
        eval_valid <= issue_active && !hit;
      end else begin
        issue_active <= 1'b0;
        eval_valid   <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Search datapath: read address, candidate tracking and result register.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      pix        <= req.color;
      issue_addr <= FIRST_ADDR;
      best_dist  <= START_DISTANCE;
      best_idx   <= req.opaque ? LAST_ADDR : '0;
    end else if (state == ST_SEARCH) begin
      if (issue_active) begin
        eval_idx   <= issue_addr;
        issue_addr <= issue_addr + FIRST_ADDR;
      end
      if (hit) begin
        best_idx <= eval_idx;
      end else if (better) begin
        best_idx  <= eval_idx;
        best_dist <= best_dist_t'(cand_dist);
      end
    end
    if (res_load) begin
      res_index <= 8'(best_idx);
    end
  end

  assign result.valid       = res_valid;
  assign result.color_index = res_index;

`ifndef SYNTHESIS
  // An evaluation is only ever pending during a search.
  a_eval_in_search: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> (state == ST_SEARCH))
    else $error("palette read evaluated outside a search");

  // No palette reads are issued once the engine is idle.
  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !issue_active)
    else $error("read issue active while idle");

  // An exact match ends the search in the next cycle.
  a_hit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && hit) |=> (state == ST_FINISH))
    else $error("exact match did not end the search");

  // Finishing with a free result slot presents a result.
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && slot_free) |=> (res_valid && state == ST_IDLE))
    else $error("finished search did not produce a result");

  // A fresh request never arrives while the engine is busy.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == ST_IDLE))
    else $error("request started while busy");
`endif

endmodule

@@ rtl/nearest_palette_color_match.sv @@
// Top level of the nearest palette color matcher.
// Loads go one per cycle when idle; a request is taken in the cycle after a result is loaded.
// A transparent pixel skips the search and goes through the finish state to the result.
// An opaque pixel reads one palette entry per cycle from the palette memory:
// the search runs from entry 1 to the last entry and ends early at an exact match.
// Reset is synchronous and clears control state; the palette holds no reset value.
module nearest_palette_color_match
  import nrpc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  nrpc_req_if.sink   request,
  nrpc_rsp_if.source result
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic           accept;
  logic           idle;
  logic           wr_en;
  palette_entry_t wr_data;
  logic [AW-1:0]  rd_addr;
  palette_entry_t rd_data;
  pixel_req_t     pix_req;

  assign accept        = request.valid && request.ready;
  assign request.ready = idle;

  // Decode a load request; slots beyond the palette are dropped.
  assign wr_en = accept && (request.func == FUNC_LOAD)
               && ({1'b0, request.entry_index} < 9'(PALETTE_ENTRIES));
  assign wr_data.red   = request.entry_red;
  assign wr_data.green = request.entry_green;
  assign wr_data.blue  = request.entry_blue;

  // Decode a pixel request and cut each color to 6 bits.
  assign pix_req.start       = accept && (request.func == FUNC_PIXEL);
  assign pix_req.opaque      = (request.pixel_alpha == OPAQUE_ALPHA);
  assign pix_req.color.red   = request.pixel_red[7:2];
  assign pix_req.color.green = request.pixel_green[7:2];
  assign pix_req.color.blue  = request.pixel_blue[7:2];

  nrpc_palette #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (request.entry_index[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nrpc_search #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .req     (pix_req),
    .idle    (idle),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .result  (result)
  );

endmodule
